// ===== design/slm_pkg.sv =====
package slm_pkg;

    // list tag carried by the func field
    typedef enum logic
    {
        LIST_FIRST  = 1'b0,
        LIST_SECOND = 1'b1
    } list_sel_t;

endpackage

// ===== design/slm_ram.sv =====
module slm_ram
#(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sorted_list_merge_top.sv =====
// Merges two ascending lists of signed values. Elements arrive one per
// transaction, tagged by func for the first or second list, with
// end_of_list on each list's final element. Once both lists are complete
// the input stalls and the block walks both buffers, emitting the merged
// ascending sequence with last on its final element; on a tie the second
// list's element goes first. Each merged element passes a registered
// buffer read in S_WAIT, held while the output stalls, then S_PICK, where
// the single compare unit picks the smaller head. Elements past LIST_DEPTH
// per list are dropped and reported on overflow of every result of that
// walk; elements sent to a list that is already complete are ignored.
module sorted_list_merge_top
#(
    parameter int LIST_DEPTH  = 32,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          end_of_list,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] merged_value,
    output logic                          last,
    output logic                          overflow
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [1:0]
    {
        S_LOAD,
        S_WAIT,
        S_PICK
    } state_t;

    state_t state_reg;
    logic [CW-1:0] first_count_reg;
    logic [CW-1:0] second_count_reg;
    logic first_done_reg;
    logic second_done_reg;
    logic dropped_reg;
    logic [CW-1:0] first_idx_reg;
    logic [CW-1:0] second_idx_reg;
    logic out_valid_reg;
    logic [VALUE_WIDTH-1:0] merged_value_reg;
    logic last_reg;
    logic overflow_reg;

    logic in_take;
    logic out_take;
    logic sel_second;
    logic first_wr;
    logic second_wr;
    logic [VALUE_WIDTH-1:0] first_head;
    logic [VALUE_WIDTH-1:0] second_head;
    logic first_left;
    logic second_left;
    logic take_first;
    logic pick_last;
    logic first_done_next;
    logic second_done_next;

    // handshake
    assign in_stall   = (state_reg != S_LOAD);
    assign in_take    = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign sel_second = (slm_pkg::list_sel_t'(func) == slm_pkg::LIST_SECOND);

    // element store decisions
    assign first_wr  = in_take && !sel_second && !first_done_reg
                       && (first_count_reg < DEPTH_C);
    assign second_wr = in_take && sel_second && !second_done_reg
                       && (second_count_reg < DEPTH_C);

    assign first_done_next  = first_done_reg
                              || (in_take && !sel_second && end_of_list);
    assign second_done_next = second_done_reg
                              || (in_take && sel_second && end_of_list);

    // list buffers
    slm_ram #(.DEPTH(LIST_DEPTH), .WIDTH(VALUE_WIDTH), .AW(AW)) u_first_ram
    (
        .clk     (clk),
        .wr_en   (first_wr),
        .wr_addr (first_count_reg[AW-1:0]),
        .wr_data (value),
        .rd_addr (first_idx_reg[AW-1:0]),
        .rd_data (first_head)
    );

    slm_ram #(.DEPTH(LIST_DEPTH), .WIDTH(VALUE_WIDTH), .AW(AW)) u_second_ram
    (
        .clk     (clk),
        .wr_en   (second_wr),
        .wr_addr (second_count_reg[AW-1:0]),
        .wr_data (value),
        .rd_addr (second_idx_reg[AW-1:0]),
        .rd_data (second_head)
    );

    // shared compare unit: smaller head wins, second list on a tie
    assign first_left  = (first_idx_reg < first_count_reg);
    assign second_left = (second_idx_reg < second_count_reg);
    assign take_first  = first_left
                         && (!second_left || ($signed(first_head) < $signed(second_head)));
    assign pick_last   = take_first
                         ? ((first_idx_reg + ONE_C == first_count_reg) && !second_left)
                         : ((second_idx_reg + ONE_C == second_count_reg) && !first_left);

    // sequencer with load counters, walk indexes and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            first_done_reg   <= 1'b0;
            second_done_reg  <= 1'b0;
            dropped_reg      <= 1'b0;
            first_idx_reg    <= '0;
            second_idx_reg   <= '0;
            out_valid_reg    <= 1'b0;
            merged_value_reg <= '0;
            last_reg         <= 1'b0;
            overflow_reg     <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_take)
                    begin
                        if (first_wr)
                        begin
                            first_count_reg <= first_count_reg + ONE_C;
                        end
                        if (second_wr)
                        begin
                            second_count_reg <= second_count_reg + ONE_C;
                        end
                        if ((!sel_second && !first_done_reg && !first_wr)
                            || (sel_second && !second_done_reg && !second_wr))
                        begin
                            dropped_reg <= 1'b1;
                        end
                        first_done_reg  <= first_done_next;
                        second_done_reg <= second_done_next;
                        if (first_done_next && second_done_next)
                        begin
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_WAIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    out_valid_reg    <= 1'b1;
                    merged_value_reg <= take_first ? first_head : second_head;
                    last_reg         <= pick_last;
                    overflow_reg     <= dropped_reg;
                    if (take_first)
                    begin
                        first_idx_reg <= first_idx_reg + ONE_C;
                    end
                    else
                    begin
                        second_idx_reg <= second_idx_reg + ONE_C;
                    end
                    if (pick_last)
                    begin
                        first_count_reg  <= '0;
                        second_count_reg <= '0;
                        first_done_reg   <= 1'b0;
                        second_done_reg  <= 1'b0;
                        dropped_reg      <= 1'b0;
                        first_idx_reg    <= '0;
                        second_idx_reg   <= '0;
                        state_reg        <= S_LOAD;
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign merged_value = merged_value_reg;
    assign last         = last_reg;
    assign overflow     = overflow_reg;

    // the walk only picks while an element remains
    a_pick_has_element: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |-> (first_left || second_left))
        else $error("pick with both lists exhausted");

    // the final pick returns the block to loading with empty lists
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK && pick_last)
        |=> (state_reg == S_LOAD && first_count_reg == '0 && second_count_reg == '0))
        else $error("lists not cleared after final pick");

    // counts never pass the buffer depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_count_reg <= DEPTH_C) && (second_count_reg <= DEPTH_C))
        else $error("list count beyond buffer depth");

    // a new result is only produced by the compare step
    a_result_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_PICK))
        else $error("result produced outside pick step");

    // the merge only starts once both lists are complete
    a_walk_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> (first_done_reg && second_done_reg))
        else $error("merge walk without both lists complete");

endmodule
